>>> src/paired_ring_canonical_rotation_macros.svh
// assertion macros shared by the checker of the paired ring canonical rotation block
// no dependencies; pulled in by `include with the bare file name
`ifndef PAIRED_RING_CANONICAL_ROTATION_MACROS_SVH
`define PAIRED_RING_CANONICAL_ROTATION_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define PRCR_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("prcr check failed: same-cycle implication");

// next-cycle implication, also live across reset
`define PRCR_ASSERT_NEXT(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("prcr check failed: next-cycle implication");

`endif

>>> src/prcr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the paired ring canonical rotation block
// no dependencies; used by the top level and its checker
`default_nettype none

package prcr_pkg;

    localparam int WORD_W  = 64;
    localparam int LEN_W   = 6;
    localparam int SHIFT_W = 5;
    localparam int MAX_CHAIN = 32;
    localparam int DBL_W   = 2 * WORD_W;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

    typedef struct packed {
        logic [WORD_W-1:0] bra_word;
        logic [WORD_W-1:0] ket_word;
    } prcr_in_t;

    typedef struct packed {
        logic [WORD_W-1:0]  canon_bra;
        logic [WORD_W-1:0]  canon_ket;
        logic [SHIFT_W-1:0] shift_count;
        logic [LEN_W-1:0]   orbit_period;
    } prcr_out_t;

    // one rotation candidate in the compare tree
    typedef struct packed {
        logic [WORD_W-1:0]  bra;
        logic [WORD_W-1:0]  ket;
        logic [SHIFT_W-1:0] shift;
        logic               ok;
    } prcr_cand_t;

endpackage

`default_nettype wire

>>> src/paired_ring_canonical_rotation.sv
`timescale 1ns / 1ps
// top level of the paired ring canonical rotation block: input stage, ring doubling,
// candidate extraction and registered compare tree; depends on prcr_pkg
`default_nettype none

// Canonical form of a (bra, ket) pair of ring words. Each word holds one 2-bit site
// per chain site, site 0 lowest, and chain_length sites are in use (0 reads as one
// site, values above MAX_SITES as MAX_SITES). Bits above the chain are dropped and
// come back as zero. Of all joint rotations the block returns the smallest pair,
// bra compared first, the earliest rotation on ties, together with that rotation
// count and the orbit period (fewest rotations restoring both words, else the chain
// length). Throughput is one request per clock unless the result side stalls. One
// stage masks the input, one forms the doubled ring words, and the rest are the
// levels of the registered minimum tree over the MAX_SITES rotations, which sets
// the depth. A stall on the result side holds each occupied stage with no empty
// stage after it; empty stages still fill, so new requests are taken while a
// result waits. chain_length must only be written while no request is in flight.
module paired_ring_canonical_rotation #(
    parameter int MAX_SITES = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [prcr_pkg::LEN_W-1:0]          cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  prcr_pkg::prcr_in_t                  s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output prcr_pkg::prcr_out_t                 m_payload
);
    import prcr_pkg::*;

    // tree shape: one leaf per rotation, padded to a power of two
    localparam int LEVELS = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int LEAVES = 1 << LEVELS;
    localparam int NODES  = LEAVES - 1;
    localparam int NSTG   = LEVELS + 2;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SITES);

    // first node of a tree level inside the flat node array
    function automatic int level_base(input int lv);
        return LEAVES - (LEAVES >> lv);
    endfunction

    // keep the earlier candidate unless the later one is strictly smaller
    function automatic prcr_cand_t pick(input prcr_cand_t a, input prcr_cand_t b);
        logic take_b;
        take_b = b.ok && (!a.ok || ({b.bra, b.ket} < {a.bra, a.ket}));
        return take_b ? b : a;
    endfunction

    // configuration
    logic [LEN_W-1:0]  chain_length_reg;

    // pipeline control
    logic [NSTG-1:0]   valid_reg;
    logic [NSTG-1:0]   valid_in;
    logic [NSTG-1:0]   load;

    // stage 0: masked words and clamped site count
    logic [LEN_W-1:0]  len_next;
    logic [WORD_W-1:0] mask_next;
    logic [WORD_W-1:0] s0_bra_reg;
    logic [WORD_W-1:0] s0_ket_reg;
    logic [WORD_W-1:0] s0_mask_reg;
    logic [LEN_W-1:0]  s0_len_reg;

    // stage 1: ring words doubled at the chain length, so each rotation is a fixed slice
    logic [DBL_W-1:0]  bra_dbl_next;
    logic [DBL_W-1:0]  ket_dbl_next;
    logic [DBL_W-1:0]  s1_bra_dbl_reg;
    logic [DBL_W-1:0]  s1_ket_dbl_reg;
    logic [WORD_W-1:0] s1_bra_reg;
    logic [WORD_W-1:0] s1_ket_reg;
    logic [WORD_W-1:0] s1_mask_reg;
    logic [LEN_W-1:0]  s1_len_reg;

    // leaves, period search and first tree level
    prcr_cand_t        leaf [LEAVES];
    prcr_cand_t        level0_next [LEAVES/2];
    logic [MAX_SITES-1:0] match_vec;
    logic [MAX_SITES-1:0] match_low;
    logic [LEN_W-1:0]  period_idx;
    logic [LEN_W-1:0]  period_next;

    // registered tree nodes, level by level, and the period riding alongside
    prcr_cand_t        tree_reg [NODES];
    logic [LEN_W-1:0]  period_reg [LEVELS];

    // ---------------------------------------------------------------------------
    // handshake: a stage loads when empty or when the stage after it moves on
    // ---------------------------------------------------------------------------
    always_comb begin
        load[NSTG-1] = !valid_reg[NSTG-1] || m_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    assign valid_in = {valid_reg[NSTG-2:0], s_valid};
    assign s_ready  = load[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (load[i]) begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_length_reg <= LEN_RESET;
        end else if (cfg_wr_en) begin
            chain_length_reg <= cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------------------
    // stage 0 logic: clamp the site count and build the chain mask
    // ---------------------------------------------------------------------------
    always_comb begin
        priority if (chain_length_reg == '0) begin
            len_next = LEN_W'(1);
        end else if (chain_length_reg > MAX_LEN) begin
            len_next = MAX_LEN;
        end else begin
            len_next = chain_length_reg;
        end
    end

    // a site is kept when its index is below the site count
    always_comb begin
        for (int j = 0; j < MAX_CHAIN; j++) begin
            mask_next[2*j +: 2] = {2{LEN_W'(j) < len_next}};
        end
    end

    // ---------------------------------------------------------------------------
    // stage 1 logic: one variable shift per word places a copy just above the chain
    // ---------------------------------------------------------------------------
    assign bra_dbl_next = {{WORD_W{1'b0}}, s0_bra_reg}
                        | ({{WORD_W{1'b0}}, s0_bra_reg} << {s0_len_reg, 1'b0});
    assign ket_dbl_next = {{WORD_W{1'b0}}, s0_ket_reg}
                        | ({{WORD_W{1'b0}}, s0_ket_reg} << {s0_len_reg, 1'b0});

    // ---------------------------------------------------------------------------
    // stage 2 logic: rotation k is the doubled word seen from site k
    // ---------------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < LEAVES; k++) begin
            leaf[k].bra   = s1_bra_dbl_reg[2*k +: WORD_W] & s1_mask_reg;
            leaf[k].ket   = s1_ket_dbl_reg[2*k +: WORD_W] & s1_mask_reg;
            leaf[k].shift = SHIFT_W'(k);
            leaf[k].ok    = (k < MAX_SITES) && (LEN_W'(k) < s1_len_reg);
        end
    end

    // period: first rotation from one upwards that restores both words
    always_comb begin
        match_vec[0] = 1'b0;
        for (int k = 1; k < MAX_SITES; k++) begin
            match_vec[k] = leaf[k].ok && (leaf[k].bra == s1_bra_reg)
                           && (leaf[k].ket == s1_ket_reg);
        end
        // isolate the lowest set bit, then encode it
        match_low  = match_vec & ((~match_vec) + {{(MAX_SITES-1){1'b0}}, 1'b1});
        period_idx = '0;
        for (int k = 0; k < MAX_SITES; k++) begin
            if (match_low[k]) begin
                period_idx = period_idx | LEN_W'(k);
            end
        end
        period_next = (match_vec == '0) ? s1_len_reg : period_idx;
    end

    always_comb begin
        for (int j = 0; j < LEAVES / 2; j++) begin
            level0_next[j] = pick(leaf[2*j], leaf[2*j+1]);
        end
    end

    // ---------------------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            s0_bra_reg  <= s_payload.bra_word & mask_next;
            s0_ket_reg  <= s_payload.ket_word & mask_next;
            s0_mask_reg <= mask_next;
            s0_len_reg  <= len_next;
        end
        if (load[1]) begin
            s1_bra_dbl_reg <= bra_dbl_next;
            s1_ket_dbl_reg <= ket_dbl_next;
            s1_bra_reg     <= s0_bra_reg;
            s1_ket_reg     <= s0_ket_reg;
            s1_mask_reg    <= s0_mask_reg;
            s1_len_reg     <= s0_len_reg;
        end
        if (load[2]) begin
            for (int j = 0; j < LEAVES / 2; j++) begin
                tree_reg[j] <= level0_next[j];
            end
            period_reg[0] <= period_next;
        end
        // remaining tree levels each halve the field, order kept for ties
        for (int lv = 1; lv < LEVELS; lv++) begin
            if (load[lv+2]) begin
                for (int j = 0; j < LEAVES / 2; j++) begin
                    if (j < (LEAVES >> (lv + 1))) begin
                        tree_reg[level_base(lv) + j] <=
                            pick(tree_reg[level_base(lv-1) + 2*j],
                                 tree_reg[level_base(lv-1) + 2*j + 1]);
                    end
                end
                period_reg[lv] <= period_reg[lv-1];
            end
        end
    end

    // ---------------------------------------------------------------------------
    // result: the tree root is the output register
    // ---------------------------------------------------------------------------
    assign m_valid                = valid_reg[NSTG-1];
    assign m_payload.canon_bra    = tree_reg[NODES-1].bra;
    assign m_payload.canon_ket    = tree_reg[NODES-1].ket;
    assign m_payload.shift_count  = tree_reg[NODES-1].shift;
    assign m_payload.orbit_period = period_reg[LEVELS-1];

endmodule

`default_nettype wire

>>> src/prcr_checker.sv
`timescale 1ns / 1ps
// port-level checker for paired_ring_canonical_rotation and its bind statement
// depends on prcr_pkg and paired_ring_canonical_rotation_macros.svh
`default_nettype none
`include "paired_ring_canonical_rotation_macros.svh"

module prcr_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_ready,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  prcr_pkg::prcr_out_t         m_payload
);
    import prcr_pkg::*;

    // synchronous reset empties the pipeline
    `PRCR_ASSERT_NEXT(a_reset_empties, aclk, !aresetn, !m_valid)

    // a stalled result stays put
    `PRCR_ASSERT_NEXT(a_result_held, aclk, aresetn && m_valid && !m_ready,
                      m_valid && $stable(m_payload))

    // with nothing at the output every stage can move, so a request is always taken
    `PRCR_ASSERT_NOW(a_taken_when_empty, aclk, aresetn, !m_valid, s_ready)

    // period lies in one to the chain maximum
    `PRCR_ASSERT_NOW(a_period_range, aclk, aresetn, m_valid,
                     (m_payload.orbit_period != '0)
                     && (m_payload.orbit_period <= LEN_W'(MAX_CHAIN)))

    // the earliest minimum falls inside the first orbit
    `PRCR_ASSERT_NOW(a_shift_in_orbit, aclk, aresetn, m_valid,
                     m_payload.orbit_period > LEN_W'(m_payload.shift_count))

endmodule

bind paired_ring_canonical_rotation prcr_checker u_prcr_checker (.*);

`default_nettype wire
